[rtl/rpmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmd_pkg
// Shared types and codes of the rational polynomial multiply/divide unit.
// ----------------------------------------------------------------------------
package rpmd_pkg;

  localparam int FUNC_W     = 2;
  localparam int SEL_W      = 2;
  localparam int IN_IDX_W   = 3;
  localparam int VALUE_IN_W = 16;
  localparam int LEN_W      = 4;   // lengths 1..8, index+1 of a 3-bit index
  localparam int TIDX_W     = 4;   // coefficient / term index inside the block
  localparam int TERM_W     = 35;
  localparam int NUM_POLYS  = 4;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [SEL_W-1:0]  sel_t;

  localparam func_t FUNC_LOAD     = 2'd0;
  localparam func_t FUNC_PRODUCT  = 2'd1;
  localparam func_t FUNC_QUOTIENT = 2'd2;
  localparam func_t FUNC_UNUSED   = 2'd3;  // accepted and ignored

  localparam sel_t SEL_A_NUM = 2'd0;
  localparam sel_t SEL_A_DEN = 2'd1;
  localparam sel_t SEL_B_NUM = 2'd2;
  localparam sel_t SEL_B_DEN = 2'd3;

  // cycles between the last read issue and the last result strobe, minus one
  localparam logic [1:0] DRAIN_CYCLES = 2'd2;

  // flags that travel with one coefficient pair down the datapath
  typedef struct packed {
    logic              valid;
    logic              first;     // first pair of a term: restart accumulator
    logic              last;      // last pair of a term: emit
    logic              part;      // 0 numerator, 1 denominator
    logic [TIDX_W-1:0] term;
    logic              fin;       // final term of the run
  } tag_t;

  typedef struct packed {
    logic              ld_en;
    sel_t              ld_sel;
    logic [TIDX_W-1:0] ld_idx;
    logic [VALUE_IN_W-1:0] ld_value;
    logic              ld_last;
    sel_t              rd_a_sel;
    logic [TIDX_W-1:0] rd_a_idx;
    sel_t              rd_b_sel;
    logic [TIDX_W-1:0] rd_b_idx;
    tag_t              tag;
  } cmd_t;

  typedef struct packed {
    logic [NUM_POLYS-1:0][LEN_W-1:0] len;
  } sts_t;

endpackage

[rtl/rpmd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rpmd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmd_ctrl
// Command sequencer: decodes loads and walks the convolution index space.
// ----------------------------------------------------------------------------
module rpmd_ctrl import rpmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  func_t                 func_i,
  input  sel_t                  operand_sel_i,
  input  logic [IN_IDX_W-1:0]   coef_index_i,
  input  logic [VALUE_IN_W-1:0] coef_value_i,
  input  logic                  last_coef_i,
  input  sts_t                  sts_i,
  output cmd_t                  cmd_o,
  output logic                  busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic              quot_q, quot_d;
  logic              part_q, part_d;
  logic              first_q, first_d;
  logic [TIDX_W-1:0] k_q, k_d;
  logic [TIDX_W-1:0] i_q, i_d;
  logic [1:0]        drain_q, drain_d;

  sel_t              pa, pb;
  logic [LEN_W-1:0]  la, lb, la_m1, i_hi;
  logic [TIDX_W:0]   lr_m1, k_nx;
  logic [TIDX_W-1:0] i_lo_nx;
  logic              i_at_hi, k_at_end, accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    if (part_q) begin
      pa = SEL_A_DEN;
      pb = quot_q ? SEL_B_NUM : SEL_B_DEN;
    end else begin
      pa = SEL_A_NUM;
      pb = quot_q ? SEL_B_DEN : SEL_B_NUM;
    end
  end

  assign la       = sts_i.len[pa];
  assign lb       = sts_i.len[pb];
  assign la_m1    = la - LEN_W'(1);
  assign lr_m1    = {1'b0, la} + {1'b0, lb} - (TIDX_W+1)'(2);
  // upper bound of i for the current k: min(la-1, k)
  assign i_hi     = (k_q < la_m1) ? k_q : la_m1;
  assign i_at_hi  = (i_q == i_hi);
  assign k_at_end = ({1'b0, k_q} == lr_m1);
  // lower bound of i for k+1: max(0, k+1-lb+1)
  assign k_nx     = {1'b0, k_q} + (TIDX_W+1)'(1);
  assign i_lo_nx  = (k_nx >= {1'b0, lb}) ?
                    TIDX_W'(k_nx - {1'b0, lb} + (TIDX_W+1)'(1)) : '0;

  always_comb begin
    cmd_o           = '0;
    cmd_o.ld_en     = 1'b0;
    cmd_o.ld_sel    = operand_sel_i;
    cmd_o.ld_idx    = TIDX_W'(coef_index_i);
    cmd_o.ld_value  = coef_value_i;
    cmd_o.ld_last   = last_coef_i;
    cmd_o.rd_a_sel  = pa;
    cmd_o.rd_a_idx  = i_q;
    cmd_o.rd_b_sel  = pb;
    cmd_o.rd_b_idx  = k_q - i_q;
    cmd_o.tag.valid = (state_q == ST_RUN);
    cmd_o.tag.first = first_q;
    cmd_o.tag.last  = i_at_hi;
    cmd_o.tag.part  = part_q;
    cmd_o.tag.term  = k_q;
    cmd_o.tag.fin   = part_q && k_at_end && i_at_hi;
    if (accept && (func_i == FUNC_LOAD)) begin
      cmd_o.ld_en = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    quot_d  = quot_q;
    part_d  = part_q;
    first_d = first_q;
    k_d     = k_q;
    i_d     = i_q;
    drain_d = drain_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_PRODUCT, FUNC_QUOTIENT: begin
              state_d = ST_RUN;
              quot_d  = (func_i == FUNC_QUOTIENT);
              part_d  = 1'b0;
              first_d = 1'b1;
              k_d     = '0;
              i_d     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        first_d = 1'b0;
        if (i_at_hi) begin
          first_d = 1'b1;
          if (k_at_end) begin
            k_d = '0;
            i_d = '0;
            if (part_q) begin
              state_d = ST_DRAIN;
              drain_d = DRAIN_CYCLES - 2'd1;
            end else begin
              part_d = 1'b1;
            end
          end else begin
            k_d = k_nx[TIDX_W-1:0];
            i_d = i_lo_nx;
          end
        end else begin
          i_d = i_q + TIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_q == 2'd0) begin
          state_d = ST_IDLE;
        end else begin
          drain_d = drain_q - 2'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      quot_q  <= 1'b0;
      part_q  <= 1'b0;
      first_q <= 1'b0;
      k_q     <= '0;
      i_q     <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      quot_q  <= quot_d;
      part_q  <= part_d;
      first_q <= first_d;
      k_q     <= k_d;
      i_q     <= i_d;
      drain_q <= drain_d;
    end
  end

endmodule

[rtl/rpmd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmd_datapath
// Coefficient store, lengths, multiplier and accumulator with result register.
// ----------------------------------------------------------------------------
module rpmd_datapath import rpmd_pkg::*; #(
  parameter int MAX_TERMS  = 8,
  parameter int COEF_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 strobe_o,
  output logic                 part_o,
  output logic [TIDX_W-1:0]    term_index_o,
  output logic [TERM_W-1:0]    term_value_o,
  output logic                 last_result_o
);

  localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int ADDR_W = SEL_W + IDX_W;
  localparam int DEPTH  = NUM_POLYS << IDX_W;
  localparam int PROD_W = 2 * COEF_WIDTH;
  localparam int PEXT_W = (PROD_W > TERM_W) ? PROD_W : TERM_W;
  localparam int VEXT_W = (COEF_WIDTH > VALUE_IN_W) ? COEF_WIDTH : VALUE_IN_W;

  logic [NUM_POLYS-1:0][LEN_W-1:0] len_q;
  logic                     ld_ok;
  logic [VEXT_W-1:0]        value_ext;
  logic [COEF_WIDTH-1:0]    wdata, rdata_a, rdata_b;
  logic [ADDR_W-1:0]        waddr, raddr_a, raddr_b;
  tag_t                     s1_q, s2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [PEXT_W-1:0]        prod_wide;
  logic [TERM_W-1:0]        prod_ext, acc_q, acc_d;
  logic                     strobe_q, part_q, last_q;
  logic [TIDX_W-1:0]        term_q;
  logic [TERM_W-1:0]        value_q;

  assign ld_ok     = cmd_i.ld_en && (int'(cmd_i.ld_idx) < MAX_TERMS);
  assign value_ext = VEXT_W'($signed(cmd_i.ld_value));
  assign wdata     = value_ext[COEF_WIDTH-1:0];
  assign waddr     = {cmd_i.ld_sel, cmd_i.ld_idx[IDX_W-1:0]};
  assign raddr_a   = {cmd_i.rd_a_sel, cmd_i.rd_a_idx[IDX_W-1:0]};
  assign raddr_b   = {cmd_i.rd_b_sel, cmd_i.rd_b_idx[IDX_W-1:0]};

  // two copies of the store so both factors of a pair read in the same cycle
  rpmd_ram #(.WIDTH(COEF_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ld_ok),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.tag.valid),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  rpmd_ram #(.WIDTH(COEF_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ld_ok),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.tag.valid),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_POLYS; p++) begin
        len_q[p] <= LEN_W'(1);
      end
    end else if (ld_ok && cmd_i.ld_last) begin
      len_q[cmd_i.ld_sel] <= LEN_W'(cmd_i.ld_idx) + LEN_W'(1);
    end
  end

  assign sts_o.len = len_q;

  // multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(rdata_a) * $signed(rdata_b);
  end

  // sums wrap modulo 2^TERM_W
  assign prod_wide = PEXT_W'(prod_q);
  assign prod_ext  = prod_wide[TERM_W-1:0];
  assign acc_d     = s2_q.first ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= '0;
      s2_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      s1_q     <= cmd_i.tag;
      s2_q     <= s1_q;
      strobe_q <= s2_q.valid && s2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q.valid) begin
      acc_q <= acc_d;
    end
    if (s2_q.valid && s2_q.last) begin
      part_q  <= s2_q.part;
      term_q  <= s2_q.term;
      value_q <= acc_d;
      last_q  <= s2_q.fin;
    end
  end

  assign strobe_o      = strobe_q;
  assign part_o        = part_q;
  assign term_index_o  = term_q;
  assign term_value_o  = value_q;
  assign last_result_o = last_q;

endmodule

[rtl/rational_polynomial_mul_div_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_polynomial_mul_div_unit
// Product or quotient of two rational transfer functions by convolution.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred when start is high and busy is low.
//   func 0 loads one coefficient (A num, A den, B num, B den selected by
//   operand_sel_i, highest power at index 0); last_coef_i sets that
//   polynomial's length. busy stays low during a load, so loads stream
//   at one per cycle.
//   func 1 (product) and func 2 (quotient) raise busy and emit the
//   numerator terms, then the denominator terms, highest power first, one
//   per strobe_o pulse; last_result_o marks the final denominator term.
//   A compute walks one coefficient pair per cycle through a two-copy
//   coefficient store, a registered multiplier and an accumulator; each
//   result passes the store's read register, the product register and
//   the result register before its strobe. busy falls in the cycle of the
//   last result strobe.
//   Results are not held: each strobe is a single-cycle transfer.
//   Reset sets every polynomial length to one; stored coefficients are
//   not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module rational_polynomial_mul_div_unit import rpmd_pkg::*; #(
  parameter int MAX_TERMS  = 8,
  parameter int COEF_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [SEL_W-1:0]      operand_sel_i,
  input  logic [IN_IDX_W-1:0]   coef_index_i,
  input  logic [VALUE_IN_W-1:0] coef_value_i,
  input  logic                  last_coef_i,
  output logic                  strobe_o,
  output logic                  part_o,
  output logic [TIDX_W-1:0]     term_index_o,
  output logic [TERM_W-1:0]     term_value_o,
  output logic                  last_result_o
);

  cmd_t cmd;
  sts_t sts;

  rpmd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .func_i        (func_i),
    .operand_sel_i (operand_sel_i),
    .coef_index_i  (coef_index_i),
    .coef_value_i  (coef_value_i),
    .last_coef_i   (last_coef_i),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .busy_o        (busy)
  );

  rpmd_datapath #(
    .MAX_TERMS  (MAX_TERMS),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .strobe_o      (strobe_o),
    .part_o        (part_o),
    .term_index_o  (term_index_o),
    .term_value_o  (term_value_o),
    .last_result_o (last_result_o)
  );

endmodule
